### rtl/bdsc_pkg.sv
// Package for the buck duty step controller.
// Holds field widths, configuration register indexes and reset values.
// No dependencies.
`default_nettype none

package bdsc_pkg;

    localparam int unsigned MV_W     = 16;
    localparam int unsigned GAIN_W   = 11;
    localparam int unsigned OFFSET_W = 11;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_MV    = 3'd0,
        CFG_DEADBAND_MV  = 3'd1,
        CFG_GAIN_Q10     = 3'd2,
        CFG_OFFSET_MV    = 3'd3,
        CFG_DUTY_FLOOR   = 3'd4,
        CFG_DUTY_CEILING = 3'd5,
        CFG_DUTY_START   = 3'd6
    } cfg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [MV_W-1:0]            TARGET_RST   = 16'd5000;
    localparam logic [MV_W-1:0]            DEADBAND_RST = 16'd100;
    localparam logic [GAIN_W-1:0]          GAIN_RST     = 11'd942;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST   = 11'sd104;
    localparam logic [DUTY_W-1:0]          FLOOR_RST    = 8'd0;
    localparam logic [DUTY_W-1:0]          CEILING_RST  = 8'd255;
    localparam logic [DUTY_W-1:0]          START_RST    = 8'd0;

endpackage

`default_nettype wire

### rtl/bdsc_if.sv
// Valid/ready channel interfaces for the buck duty step controller:
// sample input, result output and configuration write.
// Depends on bdsc_pkg.
`default_nettype none

interface bdsc_in_if
    import bdsc_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [MV_W-1:0] raw_volts;

    modport source (output valid, output raw_volts, input ready);
    modport sink   (input valid, input raw_volts, output ready);
endinterface

interface bdsc_out_if
    import bdsc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_out;
    logic [MV_W-1:0]   calibrated_mv;
    logic [MV_W-1:0]   average_mv;

    modport source (output valid, output duty_out, output calibrated_mv,
                    output average_mv, input ready);
    modport sink   (input valid, input duty_out, input calibrated_mv,
                    input average_mv, output ready);
endinterface

interface bdsc_cfg_if
    import bdsc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/buck_duty_step_controller.sv
// Buck duty step controller: calibration, deadband duty stepping, moving average.
// Samples pass the input register and then the result register; the duty, window sum
// and average feed back within the update stage; 1 item/cycle while results.ready is high.
// Reset (rst_n, async, active low) restores default registers, duty 0, cleared window.
// The window is cleared at once by per-slot valid bits; no clearing pass.
// Depends on bdsc_pkg and the channel interfaces in bdsc_if.sv.
`default_nettype none

module buck_duty_step_controller
    import bdsc_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 16   // power of two, 2..256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bdsc_in_if.sink    samples,
    bdsc_out_if.source results,
    bdsc_cfg_if.sink   cfg
);

    localparam int unsigned WIN_AW = $clog2(WINDOW_DEPTH);
    localparam int unsigned SUM_W  = MV_W + WIN_AW;
    localparam int unsigned PROD_W = MV_W + GAIN_W;
    localparam int unsigned CAL_W  = PROD_W - 10 + 2;   // scaled plus sign and carry

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    logic [MV_W-1:0]            target_reg;
    logic [MV_W-1:0]            deadband_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [DUTY_W-1:0]          floor_reg;
    logic [DUTY_W-1:0]          ceiling_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TARGET_RST;
            deadband_reg <= DEADBAND_RST;
            gain_reg     <= GAIN_RST;
            offset_reg   <= OFFSET_RST;
            floor_reg    <= FLOOR_RST;
            ceiling_reg  <= CEILING_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_TARGET_MV:    target_reg   <= cfg.data;
                CFG_DEADBAND_MV:  deadband_reg <= cfg.data;
                CFG_GAIN_Q10:     gain_reg     <= cfg.data[GAIN_W-1:0];
                CFG_OFFSET_MV:    offset_reg   <= cfg.data[OFFSET_W-1:0];
                CFG_DUTY_FLOOR:   floor_reg    <= cfg.data[DUTY_W-1:0];
                CFG_DUTY_CEILING: ceiling_reg  <= cfg.data[DUTY_W-1:0];
                // Start duty only matters at reset, and reset restores its
                // default, so the written value never takes effect: drop it.
                CFG_DUTY_START:   ;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. An item advances into the update stage when the
    // result register is empty or is being emptied this cycle.
    // ------------------------------------------------------------------
    logic            in_vld_reg;
    logic [MV_W-1:0] raw_reg;
    logic            out_vld_reg;
    logic            fire;

    assign fire          = in_vld_reg && (!out_vld_reg || results.ready);
    assign samples.ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_vld_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            raw_reg <= samples.raw_volts;
        end
    end

    // ------------------------------------------------------------------
    // Calibration: floor(raw * gain / 1024) + offset, clamped to 16 bits.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]       prod;
    logic signed [CAL_W-1:0] cal_wide;
    logic [MV_W-1:0]         cal;

    assign prod     = PROD_W'(raw_reg) * PROD_W'(gain_reg);
    assign cal_wide = $signed({2'b00, prod[PROD_W-1:10]}) + CAL_W'(offset_reg);

    always_comb
    begin
        if (cal_wide < 0)
            cal = '0;
        else if (cal_wide > $signed(CAL_W'(17'h0FFFF)))
            cal = '1;
        else
            cal = cal_wide[MV_W-1:0];
    end

    // ------------------------------------------------------------------
    // Duty stepping. The band test uses the average left by the previous
    // item; the direction uses this item's calibrated voltage. Equal
    // voltage holds the duty, and a step never crosses its limit.
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0] duty_reg;
    logic [DUTY_W-1:0] duty_next;
    logic [MV_W-1:0]   avg_reg;
    logic [MV_W-1:0]   avg_diff;
    logic              outside_band;

    assign avg_diff     = (avg_reg > target_reg) ? (avg_reg - target_reg)
                                                 : (target_reg - avg_reg);
    assign outside_band = avg_diff > deadband_reg;

    always_comb
    begin
        duty_next = duty_reg;
        if (outside_band)
        begin
            if (cal < target_reg)
            begin
                if (duty_reg < ceiling_reg)
                    duty_next = duty_reg + 1'b1;
            end
            else if (cal > target_reg)
            begin
                if (duty_reg > floor_reg)
                    duty_next = duty_reg - 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Moving-average window. The ring slot advances by one per item, so
    // the entry to be replaced next is read ahead into a registered read
    // port. A slot never written reads as zero through its valid bit.
    // ------------------------------------------------------------------
    logic [MV_W-1:0]         win_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] win_vld_reg;
    logic [WIN_AW-1:0]       slot_reg;
    logic [WIN_AW-1:0]       slot_inc;
    logic [WIN_AW-1:0]       rd_addr;
    logic [MV_W-1:0]         rd_reg;
    logic [MV_W-1:0]         oldest;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic [MV_W-1:0]         avg_next;

    assign slot_inc = slot_reg + 1'b1;
    assign rd_addr  = fire ? slot_inc : slot_reg;
    assign oldest   = win_vld_reg[slot_reg] ? rd_reg : '0;
    assign sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(cal);
    assign avg_next = sum_next[WIN_AW +: MV_W];

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            win_mem[slot_reg] <= cal;
        end
        rd_reg <= win_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Controller state and result register. State advances only when an
    // item leaves the update stage, so the next item sees it at once.
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0] res_duty_reg;
    logic [MV_W-1:0]   res_cal_reg;
    logic [MV_W-1:0]   res_avg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg    <= START_RST;
            avg_reg     <= '0;
            sum_reg     <= '0;
            slot_reg    <= '0;
            win_vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                duty_reg              <= duty_next;
                avg_reg               <= avg_next;
                sum_reg               <= sum_next;
                slot_reg              <= slot_inc;
                win_vld_reg[slot_reg] <= 1'b1;
            end
            if (fire)
                out_vld_reg <= 1'b1;
            else if (results.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_duty_reg <= duty_next;
            res_cal_reg  <= cal;
            res_avg_reg  <= avg_next;
        end
    end

    assign results.valid         = out_vld_reg;
    assign results.duty_out      = res_duty_reg;
    assign results.calibrated_mv = res_cal_reg;
    assign results.average_mv    = res_avg_reg;

endmodule

`default_nettype wire
